[design/dtp_pkg.sv]
// ----------------------------------------------------------------------------
// dtp_pkg: shared types and constants for the depth pseudocolor core
// Holds the channel payload structs, command and status codes, register
// indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package dtp_pkg;

    // Width of a depth sample and of the depth range registers.
    localparam int DEPTH_W = 16;

    // A frame of this side is emitted at BIG_SIDE by 2x2 replication.
    localparam int SMALL_SIDE = 25;
    localparam int BIG_SIDE   = 50;

    // Reset values of the configuration registers.
    localparam logic [6:0] SIDE_RESET = 7'd25;
    localparam logic [8:0] CMAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        CMD_LOAD_ENTRY = 2'd0,
        CMD_PUSH_DEPTH = 2'd1,
        CMD_EMIT_PIXEL = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_MIN_MM     = 2'd0,
        REG_MAX_MM     = 2'd1,
        REG_FRAME_SIDE = 2'd2,
        REG_CMAP_SIZE  = 2'd3
    } reg_index_t;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] depth_mm;
        logic [7:0]  entry_index;
        logic [7:0]  entry_red;
        logic [7:0]  entry_green;
        logic [7:0]  entry_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] pixel_x;
        logic [6:0] pixel_y;
        logic       last_pixel;
        logic       status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POS_WAIT,
        ST_ADDR,
        ST_OFFSET,
        ST_MULT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_LOOKUP,
        ST_COLOR,
        ST_RESULT
    } state_t;

endpackage

[design/dtp_ram.sv]
// ----------------------------------------------------------------------------
// dtp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dtp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/dtp_div.sv]
// ----------------------------------------------------------------------------
// dtp_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses when quotient and
// remainder are ready, and they hold until the next start.
// ----------------------------------------------------------------------------
module dtp_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] remd
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end else if (busy_reg) begin
            // Shift the next numerator bit in and subtract when it fits.
            rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;
    assign remd = rem_reg;

endmodule

[design/depth_to_pseudocolor_core.sv]
// ----------------------------------------------------------------------------
// depth_to_pseudocolor_core: depth frame to pseudocolor pixel converter
// Stores a colormap and one square depth frame, then emits one RGB pixel per
// emit request with the depth normalized into a colormap index.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                               Moves
//  --------  ----------------------------------  -------------------------------
//  input     s_valid, s_ready, s_data            one command per transfer
//  result    m_valid, m_ready, m_data            one pixel per emit command
//  config    cfg_wr_en, cfg_wr_index, cfg_wr_data  register write, no wait
//
// Load, push and clear commands pass through the decode state back to idle.
// An emit on a complete frame steps through the address, offset, multiply,
// divide, lookup, color and result states; the iterative divider (NUM_W =
// 16 + log2(TABLE_DEPTH)) gives one quotient bit per cycle. An emit after a
// frame_side write first runs the same divider to recover the output
// position. An emit on an incomplete frame goes straight to the result state.
// Reset is synchronous and needs no clearing pass. A stalled result waits in
// the output register while the next command is taken; a following emit then
// holds in its last state until the output register frees.
// ----------------------------------------------------------------------------
module depth_to_pseudocolor_core #(
    parameter int MAX_SIDE    = 100,
    parameter int TABLE_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  dtp_pkg::in_item_t  s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output dtp_pkg::out_item_t m_data,

    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_index,
    input  logic [15:0]        cfg_wr_data
);

    // Frame store geometry. The output image of a replicated frame can hold
    // more pixels than the frame store when MAX_SIDE is small.
    localparam int FS_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int FA_W     = (FS_DEPTH > 1) ? $clog2(FS_DEPTH) : 1;
    localparam int SL_W     = $clog2(FS_DEPTH + 1);
    localparam int OT_MAX   = (MAX_SIDE >= dtp_pkg::SMALL_SIDE &&
                               dtp_pkg::BIG_SIDE * dtp_pkg::BIG_SIDE > FS_DEPTH) ?
                              dtp_pkg::BIG_SIDE * dtp_pkg::BIG_SIDE : FS_DEPTH;
    localparam int OT_W     = $clog2(OT_MAX + 1);
    localparam int SIDE_CAP = (MAX_SIDE > 127) ? 127 : MAX_SIDE;

    // Colormap geometry; the scaled offset is a depth times (size - 1).
    localparam int TA_W  = $clog2(TABLE_DEPTH);
    localparam int PW    = dtp_pkg::DEPTH_W + TA_W;
    localparam int DEP_W = dtp_pkg::DEPTH_W;

    // Configuration registers.
    logic [15:0] min_mm_reg, min_mm_next;
    logic [15:0] max_mm_reg, max_mm_next;
    logic [6:0]  side_cfg_reg, side_cfg_next;
    logic [8:0]  cmap_cfg_reg, cmap_cfg_next;

    // Values derived from configuration and frame statistics, registered.
    logic [6:0]      side_reg, side_next;
    logic            up_reg, up_next;
    logic [6:0]      oside_reg, oside_next;
    logic [SL_W-1:0] total_reg, total_next;
    logic [OT_W-1:0] ototal_reg, ototal_next;
    logic [TA_W-1:0] sm1_reg, sm1_next;
    logic [DEP_W-1:0] lo_reg, lo_next;
    logic [DEP_W-1:0] range_reg, range_next;

    // Frame state.
    logic [DEP_W-1:0] rmin_reg, rmin_next;
    logic [DEP_W-1:0] rmax_reg, rmax_next;
    logic [SL_W-1:0]  loaded_reg, loaded_next;
    logic [OT_W-1:0]  emitted_reg, emitted_next;
    logic [6:0]       px_reg, px_next;
    logic [6:0]       py_reg, py_next;
    logic             pos_ok_reg, pos_ok_next;

    // Sequencer and datapath.
    dtp_pkg::state_t    state_reg, state_next;
    dtp_pkg::in_item_t  item_reg, item_next;
    dtp_pkg::out_item_t res_reg, res_next;
    logic [DEP_W-1:0]   off_reg, off_next;
    logic [PW-1:0]      prod_reg, prod_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    dtp_pkg::out_item_t m_data_reg, m_data_next;

    // Memory and divider hookup.
    logic             fs_wr_en, fs_rd_en;
    logic [FA_W-1:0]  fs_wr_addr, fs_rd_addr;
    logic [DEP_W-1:0] fs_rd_data;
    logic             ct_wr_en, ct_rd_en;
    logic [TA_W-1:0]  ct_wr_addr, ct_rd_addr;
    logic [23:0]      ct_rd_data;
    logic             div_start;
    logic [PW-1:0]    div_numer;
    logic [DEP_W-1:0] div_denom;
    logic             div_done;
    logic [PW-1:0]    div_quot;
    logic [DEP_W-1:0] div_remd;

    // Helpers.
    logic [7:0]       side_wide;
    logic [10:0]      cmap_wide;
    logic [10:0]      cmap_eff;
    logic [10:0]      entry_wide;
    logic [6:0]       src_x, src_y;
    logic [13:0]      src_addr;
    logic [OT_W:0]    emitted_inc;
    logic             last_pix;
    logic [7:0]       px_inc;

    // ------------------------------------------------------------------
    // Derived values: effective side, output side, pixel counts,
    // effective colormap size and the depth range.
    // ------------------------------------------------------------------
    always_comb begin
        side_wide = {1'b0, side_cfg_reg};
        if (side_cfg_reg == 7'd0) begin
            side_next = 7'd1;
        end else if (side_wide > 8'(SIDE_CAP)) begin
            side_next = 7'(SIDE_CAP);
        end else begin
            side_next = side_cfg_reg;
        end
        up_next     = (side_reg == 7'(dtp_pkg::SMALL_SIDE));
        oside_next  = up_reg ? 7'(dtp_pkg::BIG_SIDE) : side_reg;
        total_next  = SL_W'({7'd0, side_reg} * {7'd0, side_reg});
        ototal_next = OT_W'({7'd0, oside_reg} * {7'd0, oside_reg});

        cmap_wide = {2'b00, cmap_cfg_reg};
        if (cmap_cfg_reg == 9'd0) begin
            cmap_eff = 11'd1;
        end else if (cmap_wide > 11'(TABLE_DEPTH)) begin
            cmap_eff = 11'(TABLE_DEPTH);
        end else begin
            cmap_eff = cmap_wide;
        end
        sm1_next = TA_W'(cmap_eff - 11'd1);

        // A programmed range wins; otherwise the frame's own extremes are
        // used, and a flat frame gets a range of one.
        if (max_mm_reg > min_mm_reg) begin
            lo_next    = min_mm_reg;
            range_next = max_mm_reg - min_mm_reg;
        end else begin
            lo_next    = rmin_reg;
            range_next = (rmax_reg > rmin_reg) ? rmax_reg - rmin_reg : DEP_W'(1);
        end
    end

    // Source sample of the current output pixel; replication halves both
    // coordinates.
    assign src_x    = up_reg ? (px_reg >> 1) : px_reg;
    assign src_y    = up_reg ? (py_reg >> 1) : py_reg;
    assign src_addr = ({7'd0, src_y} * {7'd0, side_reg}) + {7'd0, src_x};

    assign emitted_inc = {1'b0, emitted_reg} + 1'b1;
    assign last_pix    = (emitted_inc == {1'b0, ototal_reg});
    assign px_inc      = {1'b0, px_reg} + 8'd1;
    assign entry_wide  = {3'b000, item_reg.entry_index};

    // ------------------------------------------------------------------
    // Sequencer: next state, memory strobes, divider requests and all
    // state updates.
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        off_next      = off_reg;
        prod_next     = prod_reg;
        rmin_next     = rmin_reg;
        rmax_next     = rmax_reg;
        loaded_next   = loaded_reg;
        emitted_next  = emitted_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pos_ok_next   = pos_ok_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        min_mm_next   = min_mm_reg;
        max_mm_next   = max_mm_reg;
        side_cfg_next = side_cfg_reg;
        cmap_cfg_next = cmap_cfg_reg;

        fs_wr_en   = 1'b0;
        fs_wr_addr = loaded_reg[FA_W-1:0];
        fs_rd_en   = 1'b0;
        fs_rd_addr = src_addr[FA_W-1:0];
        ct_wr_en   = 1'b0;
        ct_wr_addr = entry_wide[TA_W-1:0];
        ct_rd_en   = 1'b0;
        ct_rd_addr = sm1_reg - div_quot[TA_W-1:0];
        div_start  = 1'b0;
        div_numer  = prod_reg;
        div_denom  = range_reg;

        case (state_reg)
            dtp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = dtp_pkg::ST_DECODE;
                end
            end

            dtp_pkg::ST_DECODE: begin
                state_next = dtp_pkg::ST_IDLE;
                case (item_reg.command)
                    dtp_pkg::CMD_LOAD_ENTRY: begin
                        // Addresses past the table are dropped.
                        ct_wr_en = (entry_wide < 11'(TABLE_DEPTH));
                    end
                    dtp_pkg::CMD_PUSH_DEPTH: begin
                        if (loaded_reg < total_reg) begin
                            fs_wr_en    = 1'b1;
                            loaded_next = loaded_reg + 1'b1;
                            if (item_reg.depth_mm < rmin_reg) begin
                                rmin_next = item_reg.depth_mm;
                            end
                            if (item_reg.depth_mm > rmax_reg) begin
                                rmax_next = item_reg.depth_mm;
                            end
                        end
                    end
                    dtp_pkg::CMD_CLEAR: begin
                        loaded_next  = '0;
                        emitted_next = '0;
                        px_next      = '0;
                        py_next      = '0;
                        pos_ok_next  = 1'b1;
                        rmin_next    = '1;
                        rmax_next    = '0;
                    end
                    dtp_pkg::CMD_EMIT_PIXEL: begin
                        if (loaded_reg < total_reg) begin
                            res_next        = '0;
                            res_next.status = dtp_pkg::STATUS_NO_FRAME;
                            state_next      = dtp_pkg::ST_RESULT;
                        end else if (emitted_reg >= ototal_reg) begin
                            // Position ran past a shrunken image: restart.
                            emitted_next = '0;
                            px_next      = '0;
                            py_next      = '0;
                            pos_ok_next  = 1'b1;
                            state_next   = dtp_pkg::ST_ADDR;
                        end else if (!pos_ok_reg) begin
                            // The side changed: row and column come from the
                            // pixel count divided by the output side.
                            div_start  = 1'b1;
                            div_numer  = PW'(emitted_reg);
                            div_denom  = DEP_W'(oside_reg);
                            state_next = dtp_pkg::ST_POS_WAIT;
                        end else begin
                            state_next = dtp_pkg::ST_ADDR;
                        end
                    end
                    default: begin
                        state_next = dtp_pkg::ST_IDLE;
                    end
                endcase
            end

            dtp_pkg::ST_POS_WAIT: begin
                if (div_done) begin
                    py_next     = div_quot[6:0];
                    px_next     = div_remd[6:0];
                    pos_ok_next = 1'b1;
                    state_next  = dtp_pkg::ST_ADDR;
                end
            end

            dtp_pkg::ST_ADDR: begin
                fs_rd_en   = 1'b1;
                state_next = dtp_pkg::ST_OFFSET;
            end

            dtp_pkg::ST_OFFSET: begin
                // Clamp the sample into [lo, lo + range].
                off_next = (fs_rd_data > lo_reg) ? fs_rd_data - lo_reg : '0;
                if (off_next > range_reg) begin
                    off_next = range_reg;
                end
                state_next = dtp_pkg::ST_MULT;
            end

            dtp_pkg::ST_MULT: begin
                prod_next  = {{TA_W{1'b0}}, off_reg} * {{DEP_W{1'b0}}, sm1_reg};
                state_next = dtp_pkg::ST_DIV_START;
            end

            dtp_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = dtp_pkg::ST_DIV_WAIT;
            end

            dtp_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = dtp_pkg::ST_LOOKUP;
                end
            end

            dtp_pkg::ST_LOOKUP: begin
                // The quotient never exceeds size - 1, so the index stays
                // inside the table.
                ct_rd_en   = 1'b1;
                state_next = dtp_pkg::ST_COLOR;
            end

            dtp_pkg::ST_COLOR: begin
                res_next.red        = ct_rd_data[23:16];
                res_next.green      = ct_rd_data[15:8];
                res_next.blue       = ct_rd_data[7:0];
                res_next.pixel_x    = px_reg;
                res_next.pixel_y    = py_reg;
                res_next.last_pixel = last_pix;
                res_next.status     = dtp_pkg::STATUS_OK;
                if (last_pix) begin
                    emitted_next = '0;
                    px_next      = '0;
                    py_next      = '0;
                end else begin
                    emitted_next = emitted_inc[OT_W-1:0];
                    if (px_inc == {1'b0, oside_reg}) begin
                        px_next = '0;
                        py_next = py_reg + 7'd1;
                    end else begin
                        px_next = px_inc[6:0];
                    end
                end
                state_next = dtp_pkg::ST_RESULT;
            end

            dtp_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = dtp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = dtp_pkg::ST_IDLE;
            end
        endcase

        // Configuration writes must arrive with the sequencer idle; unchecked.
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                dtp_pkg::REG_MIN_MM:     min_mm_next   = cfg_wr_data;
                dtp_pkg::REG_MAX_MM:     max_mm_next   = cfg_wr_data;
                dtp_pkg::REG_FRAME_SIDE: begin
                    side_cfg_next = cfg_wr_data[6:0];
                    pos_ok_next   = 1'b0;
                end
                dtp_pkg::REG_CMAP_SIZE:  cmap_cfg_next = cfg_wr_data[8:0];
                default: begin
                    min_mm_next = min_mm_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dtp_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            min_mm_reg   <= '0;
            max_mm_reg   <= '0;
            side_cfg_reg <= dtp_pkg::SIDE_RESET;
            cmap_cfg_reg <= dtp_pkg::CMAP_RESET;
            side_reg     <= dtp_pkg::SIDE_RESET;
            up_reg       <= 1'b0;
            oside_reg    <= dtp_pkg::SIDE_RESET;
            total_reg    <= '0;
            ototal_reg   <= '0;
            sm1_reg      <= '0;
            lo_reg       <= '0;
            range_reg    <= DEP_W'(1);
            rmin_reg     <= '1;
            rmax_reg     <= '0;
            loaded_reg   <= '0;
            emitted_reg  <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            pos_ok_reg   <= 1'b1;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            min_mm_reg   <= min_mm_next;
            max_mm_reg   <= max_mm_next;
            side_cfg_reg <= side_cfg_next;
            cmap_cfg_reg <= cmap_cfg_next;
            side_reg     <= side_next;
            up_reg       <= up_next;
            oside_reg    <= oside_next;
            total_reg    <= total_next;
            ototal_reg   <= ototal_next;
            sm1_reg      <= sm1_next;
            lo_reg       <= lo_next;
            range_reg    <= range_next;
            rmin_reg     <= rmin_next;
            rmax_reg     <= rmax_next;
            loaded_reg   <= loaded_next;
            emitted_reg  <= emitted_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            pos_ok_reg   <= pos_ok_next;
        end
        item_reg   <= item_next;
        res_reg    <= res_next;
        off_reg    <= off_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == dtp_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Depth frame, written in row-major order.
    dtp_ram #(
        .WIDTH (DEP_W),
        .DEPTH (FS_DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (fs_wr_en),
        .wr_addr (fs_wr_addr),
        .wr_data (item_reg.depth_mm),
        .rd_en   (fs_rd_en),
        .rd_addr (fs_rd_addr),
        .rd_data (fs_rd_data)
    );

    // Colormap, one packed RGB word per entry.
    dtp_ram #(
        .WIDTH (24),
        .DEPTH (TABLE_DEPTH)
    ) u_cmap_ram (
        .aclk    (aclk),
        .wr_en   (ct_wr_en),
        .wr_addr (ct_wr_addr),
        .wr_data ({item_reg.entry_red, item_reg.entry_green, item_reg.entry_blue}),
        .rd_en   (ct_rd_en),
        .rd_addr (ct_rd_addr),
        .rd_data (ct_rd_data)
    );

    // Shared divider: output position after a side change, and the scaled
    // offset over the depth range for every pixel.
    dtp_div #(
        .NUM_W (PW),
        .DEN_W (DEP_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (div_quot),
        .remd    (div_remd)
    );

endmodule

[design/dtp_checker.sv]
// ----------------------------------------------------------------------------
// dtp_checker: port-level checks for the depth pseudocolor core
// Watches the input and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module dtp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input dtp_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input dtp_pkg::out_item_t m_data
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One command at a time: after a transfer the input side closes.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    // A missing frame gives an all-zero pixel.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == dtp_pkg::STATUS_NO_FRAME) |->
            m_data.red == 8'd0 && m_data.green == 8'd0 && m_data.blue == 8'd0 &&
            m_data.pixel_x == 7'd0 && m_data.pixel_y == 7'd0 && !m_data.last_pixel)
        else $error("error result carries pixel data");

    // The end-of-image mark only comes with a good pixel.
    a_last_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_pixel |-> m_data.status == dtp_pkg::STATUS_OK)
        else $error("last pixel flagged on an error result");

endmodule

bind depth_to_pseudocolor_core dtp_checker u_dtp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[bench/tb_depth_to_pseudocolor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_to_pseudocolor_core: self-checking bench for the pseudocolor core
// Drives colormap loads, depth pushes, emits and clears through the input
// channel, runs each accepted command through a bit-accurate pixel predictor,
// and checks every result transfer field by field against the oldest
// expected pixel. A short scripted sequence comes first, then randomized
// frame sequences under several range, side and colormap settings.
// ----------------------------------------------------------------------------
module tb_depth_to_pseudocolor_core;
    import dtp_pkg::*;

    localparam int MAX_SIDE    = 100;
    localparam int TABLE_DEPTH = 256;
    localparam int REPLICATE   = 2;
    localparam int LIMIT       = 1000000;
    // The slowest emit runs its divider twice after a side change, and SETTLE
    // covers any command still in progress.
    localparam int SETTLE      = 80;
    localparam int HOLD_CYCLES = 400;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;

    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;

    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_index;
    logic [15:0] cfg_wr_data;

    depth_to_pseudocolor_core #(
        .MAX_SIDE    (MAX_SIDE),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 12 ns period clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Pixel predictor state. It mirrors the core's registers, colormap, frame
    // store and running statistics, and is updated at the edge where each
    // command transfer or register write happens.
    // ------------------------------------------------------------------------
    logic [15:0] min_reg  = 16'd0;
    logic [15:0] max_reg  = 16'd0;
    logic [6:0]  side_reg = SIDE_RESET;
    logic [8:0]  cmap_reg = CMAP_RESET;
    logic [23:0] palette [TABLE_DEPTH];
    logic [15:0] depth_frame [MAX_SIDE * MAX_SIDE];
    logic [15:0] low_seen  = 16'hFFFF;
    logic [15:0] high_seen = 16'h0000;
    int          loaded    = 0;
    int          emitted   = 0;

    // Expected pixels in the order their emit commands were accepted.
    out_item_t pending_pixels [$];

    int commands_sent  = 0;
    int pixels_checked = 0;
    int no_frame_seen  = 0;
    int writes_done    = 0;
    int mismatches     = 0;
    int hold_asked     = 0;

    // The side register acts as 1 when zero and saturates at MAX_SIDE.
    function automatic int frame_edge();
        if (side_reg == 7'd0) return 1;
        if (side_reg > MAX_SIDE) return MAX_SIDE;
        return side_reg;
    endfunction

    // Applies one command to the predictor and returns 1 with the expected
    // pixel when the command produces a result transfer.
    function automatic bit colorize(input in_item_t c, output out_item_t px);
        int          side, total, oside, ototal, col, row, src, size, idx;
        bit          up;
        longint      lo, hi, span, off;
        logic [23:0] rgb;

        side  = frame_edge();
        total = side * side;
        px    = '0;
        case (c.command)
            CMD_LOAD_ENTRY: begin
                palette[c.entry_index] = {c.entry_red, c.entry_green, c.entry_blue};
                return 1'b0;
            end
            CMD_PUSH_DEPTH: begin
                // A sample into a complete frame is dropped and leaves the
                // running minimum and maximum alone.
                if (loaded < total) begin
                    depth_frame[loaded] = c.depth_mm;
                    loaded++;
                    if (c.depth_mm < low_seen) low_seen = c.depth_mm;
                    if (c.depth_mm > high_seen) high_seen = c.depth_mm;
                end
                return 1'b0;
            end
            CMD_CLEAR: begin
                loaded    = 0;
                emitted   = 0;
                low_seen  = 16'hFFFF;
                high_seen = 16'h0000;
                return 1'b0;
            end
            default: ;
        endcase

        if (loaded < total) begin
            px.status = STATUS_NO_FRAME;
            return 1'b1;
        end

        // A 25x25 frame goes out as 50x50, each sample covering 2x2 pixels.
        up     = (side == SMALL_SIDE);
        oside  = up ? BIG_SIDE : side;
        ototal = oside * oside;
        if (emitted >= ototal) emitted = 0;
        col = emitted % oside;
        row = emitted / oside;
        src = (up ? row / REPLICATE : row) * side + (up ? col / REPLICATE : col);

        if (max_reg > min_reg) begin
            lo = min_reg;
            hi = max_reg;
        end else begin
            lo = low_seen;
            hi = high_seen;
            if (hi <= lo) hi = lo + 1;
        end
        span = hi - lo;
        off  = (depth_frame[src] > lo) ? longint'(depth_frame[src]) - lo : 0;
        if (off > span) off = span;

        if (cmap_reg == 9'd0) size = 1;
        else if (cmap_reg > TABLE_DEPTH) size = TABLE_DEPTH;
        else size = cmap_reg;
        idx = (size - 1) - int'((off * (size - 1)) / span);
        rgb = palette[idx];

        px.red        = rgb[23:16];
        px.green      = rgb[15:8];
        px.blue       = rgb[7:0];
        px.pixel_x    = col[6:0];
        px.pixel_y    = row[6:0];
        px.last_pixel = (emitted + 1 == ototal);
        px.status     = STATUS_OK;
        emitted++;
        if (emitted >= ototal) emitted = 0;
        return 1'b1;
    endfunction

    function automatic in_item_t make_cmd(cmd_t op, logic [15:0] depth, logic [7:0] addr,
                                          logic [23:0] rgb);
        in_item_t c;
        c.command     = op;
        c.depth_mm    = depth;
        c.entry_index = addr;
        c.entry_red   = rgb[23:16];
        c.entry_green = rgb[15:8];
        c.entry_blue  = rgb[7:0];
        return c;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        // Keep the log readable when a broken core fails on every pixel.
        if (mismatches <= 50) $display("MISMATCH: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Idling. The run is split in thirds by commands sent: sender idle 37% and
    // receiver idle 72%, then the reverse, then no idling at all.
    // ------------------------------------------------------------------------
    function automatic int sender_idle_pct();
        if (commands_sent < 600) return 37;
        if (commands_sent < 1200) return 72;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (commands_sent < 600) return 72;
        if (commands_sent < 1200) return 37;
        return 0;
    endfunction

    // Result ready is driven at the falling edge. When the stimulus asks for
    // a hold-off, ready stays low for a long stretch counted here, so the
    // core's output register fills and its input stalls.
    int hold_served = 0;
    int hold_left   = 0;
    always @(negedge aclk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every transfer on the result channel is matched with
    // the oldest expected pixel.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        string     diffs;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                note_mismatch($sformatf("pixel %h arrived with no emit waiting", m_data));
            end else begin
                want  = pending_pixels.pop_front();
                diffs = "";
                if (m_data.red !== want.red)
                    diffs = {diffs, $sformatf(" red %h/%h", m_data.red, want.red)};
                if (m_data.green !== want.green)
                    diffs = {diffs, $sformatf(" green %h/%h", m_data.green, want.green)};
                if (m_data.blue !== want.blue)
                    diffs = {diffs, $sformatf(" blue %h/%h", m_data.blue, want.blue)};
                if (m_data.pixel_x !== want.pixel_x)
                    diffs = {diffs, $sformatf(" x %0d/%0d", m_data.pixel_x, want.pixel_x)};
                if (m_data.pixel_y !== want.pixel_y)
                    diffs = {diffs, $sformatf(" y %0d/%0d", m_data.pixel_y, want.pixel_y)};
                if (m_data.last_pixel !== want.last_pixel)
                    diffs = {diffs, $sformatf(" last %b/%b", m_data.last_pixel,
                                              want.last_pixel)};
                if (m_data.status !== want.status)
                    diffs = {diffs, $sformatf(" status %b/%b", m_data.status, want.status)};
                if (diffs != "")
                    note_mismatch($sformatf("pixel %0d (got/expected):%s",
                                            pixels_checked, diffs));
                pixels_checked++;
                if (want.status == STATUS_NO_FRAME) no_frame_seen++;
            end
        end
    end

    // Watchdog: ends the run if it has not finished well past its slowest
    // legal length.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one command, holds it until the transfer, then predicts it. A
    // typed expectation, where given, stands in for the predicted pixel.
    task automatic send_cmd(input in_item_t c, input bit typed = 1'b0,
                            input out_item_t want = '0);
        out_item_t px;
        while ($urandom_range(99) < sender_idle_pct()) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        commands_sent++;
        if (colorize(c, px)) pending_pixels.push_back(typed ? want : px);
    endtask

    task automatic send_emit();
        send_cmd(make_cmd(CMD_EMIT_PIXEL, 16'($urandom), 8'($urandom), 24'($urandom)));
    endtask

    // Stops offering, waits for every expected pixel, then lingers so that
    // any load, push or clear still in the core has finished.
    task automatic wait_for_idle(input int linger);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (linger) @(posedge aclk);
    endtask

    task automatic set_register(input reg_index_t r, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= r;
        cfg_wr_data  <= value;
        case (r)
            REG_MIN_MM:     min_reg  = value;
            REG_MAX_MM:     max_reg  = value;
            REG_FRAME_SIDE: side_reg = value[6:0];
            REG_CMAP_SIZE:  cmap_reg = value[8:0];
            default: ;
        endcase
        writes_done++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Depth samples shaped per frame: uniform, clustered, flat, extremes,
    // or spread just around the configured range so clamping is exercised.
    function automatic logic [15:0] pick_depth(int style, int base);
        int d;
        case (style)
            0: d = $urandom_range(65535);
            1: d = base + $urandom_range(63);
            2: d = base;
            3: begin
                case ($urandom_range(2))
                    0: d = 0;
                    1: d = 65535;
                    default: d = $urandom_range(65535);
                endcase
            end
            default: d = $urandom_range(int'(max_reg) + 40, int'(min_reg) - 40 > 0 ?
                                        int'(min_reg) - 40 : 0);
        endcase
        if (d > 65535) d = 65535;
        return 16'(d);
    endfunction

    // One configuration setting followed by random traffic. Where frames fit, most
    // of it is complete frames (clear, fill, emit a run of pixels); the rest is noise.
    // The few emits at the head land on whatever the previous phase left,
    // which covers a side change under a loaded frame.
    task automatic run_phase(input logic [15:0] lo_mm, input logic [15:0] hi_mm,
                             input logic [15:0] side_val, input logic [15:0] cmap_val,
                             input int budget, input bit frames_fit, input bit want_hold);
        int start, total, oside, n_emit, style, base, extra, k;
        wait_for_idle(SETTLE);
        set_register(REG_MIN_MM, lo_mm);
        set_register(REG_MAX_MM, hi_mm);
        set_register(REG_FRAME_SIDE, side_val);
        set_register(REG_CMAP_SIZE, cmap_val);
        start = commands_sent;
        repeat ($urandom_range(1, 3)) send_emit();
        while (commands_sent - start < budget) begin
            if (frames_fit && $urandom_range(99) < 80) begin
                total = frame_edge() * frame_edge();
                oside = (frame_edge() == SMALL_SIDE) ? BIG_SIDE : frame_edge();
                style = $urandom_range(4);
                base  = $urandom_range(65535 - 63);
                extra = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
                send_cmd(make_cmd(CMD_CLEAR, 16'($urandom), 8'($urandom), 24'($urandom)));
                for (k = 0; k < total + extra; k++) begin
                    if ($urandom_range(99) < 4)
                        send_cmd(make_cmd(CMD_LOAD_ENTRY, 16'($urandom), 8'($urandom),
                                          24'($urandom)));
                    send_cmd(make_cmd(CMD_PUSH_DEPTH, pick_depth(style, base),
                                      8'($urandom), 24'($urandom)));
                end
                // The receiver holds off while this frame's emits are offered.
                if (want_hold) begin
                    hold_asked++;
                    want_hold = 1'b0;
                end
                if (oside * oside > 100)
                    n_emit = $urandom_range(1, 40);
                else if ($urandom_range(9) < 3)
                    n_emit = oside * oside + $urandom_range(3);
                else
                    n_emit = $urandom_range(1, oside * oside < 24 ? oside * oside : 24);
                repeat (n_emit) send_emit();
                // Now and then the sender pauses until every pixel is back.
                if ($urandom_range(3) == 0) wait_for_idle(0);
            end else begin
                send_cmd(make_cmd(cmd_t'($urandom_range(3)), 16'($urandom), 8'($urandom),
                                  24'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Scripted opening on a 2x2 frame with a two-entry colormap and automatic
    // range. Rows with typed results are the no-frame errors and the pixels
    // at the depth extremes; the others go through the predictor.
    // ------------------------------------------------------------------------
    typedef struct {
        cmd_t        op;
        logic [15:0] depth;
        logic [7:0]  addr;
        logic [23:0] rgb;
        bit          typed;
        logic [23:0] want_rgb;
        int          want_x;
        int          want_y;
        bit          want_last;
        bit          want_status;
    } script_row_t;

    localparam int SCRIPT_ROWS = 23;
    script_row_t script [SCRIPT_ROWS] = '{
        // Emit straight after reset: nothing loaded yet.
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 1, 24'h000000, 0, 0, 0, 1},
        '{CMD_LOAD_ENTRY, 16'd0,     8'd0,   24'hFF00FF, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_LOAD_ENTRY, 16'd0,     8'd1,   24'h00FF00, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_LOAD_ENTRY, 16'd0,     8'd255, 24'h123456, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_PUSH_DEPTH, 16'd1000,  8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        // Frame only partly loaded.
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 1, 24'h000000, 0, 0, 0, 1},
        '{CMD_PUSH_DEPTH, 16'd2000,  8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_PUSH_DEPTH, 16'd3000,  8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_PUSH_DEPTH, 16'd4000,  8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        // Extra sample into the full frame must be dropped.
        '{CMD_PUSH_DEPTH, 16'd0,     8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        // Deepest sample at the top of the range, last pixel of the image.
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 1, 24'hFF00FF, 1, 1, 1, 0},
        // Wraps back to the first pixel.
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_CLEAR,      16'd0,     8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 1, 24'h000000, 0, 0, 0, 1},
        '{CMD_PUSH_DEPTH, 16'd0,     8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_PUSH_DEPTH, 16'd65535, 8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_PUSH_DEPTH, 16'd65535, 8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        '{CMD_PUSH_DEPTH, 16'd0,     8'd0,   24'h000000, 0, 24'h000000, 0, 0, 0, 0},
        // Depth 0 and 65535 land on the opposite ends of the colormap.
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 1, 24'h00FF00, 0, 0, 0, 0},
        '{CMD_EMIT_PIXEL, 16'd0,     8'd0,   24'h000000, 1, 24'hFF00FF, 1, 0, 0, 0}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int        i;
        out_item_t want;

        s_valid      = 1'b0;
        s_data       = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_MIN_MM;
        cfg_wr_data  = 16'd0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_register(REG_FRAME_SIDE, 16'd2);
        set_register(REG_CMAP_SIZE, 16'd2);
        for (i = 0; i < SCRIPT_ROWS; i++) begin
            want             = '0;
            want.red         = script[i].want_rgb[23:16];
            want.green       = script[i].want_rgb[15:8];
            want.blue        = script[i].want_rgb[7:0];
            want.pixel_x     = 7'(script[i].want_x);
            want.pixel_y     = 7'(script[i].want_y);
            want.last_pixel  = script[i].want_last;
            want.status      = script[i].want_status ? STATUS_NO_FRAME : STATUS_OK;
            send_cmd(make_cmd(script[i].op, script[i].depth, script[i].addr, script[i].rgb),
                     script[i].typed, want);
        end

        // Fill the whole colormap so that any index a later emit computes
        // reads a written entry.
        for (i = 0; i < TABLE_DEPTH; i++)
            send_cmd(make_cmd(CMD_LOAD_ENTRY, 16'($urandom), 8'(i), 24'($urandom)));

        //        min    max    side cmap budget fit hold
        run_phase(0,     0,     4,   16,  150,   1,  1);
        run_phase(100,   200,   1,   1,   80,    1,  0);
        // Zero side and size act as one; equal bounds select auto range.
        run_phase(500,   500,   0,   0,   60,    1,  0);
        run_phase(0,     65535, 8,   256, 180,   1,  1);
        // Inverted bounds select auto range; size above the table saturates.
        run_phase(65535, 0,     3,   511, 100,   1,  0);
        // The replicated 25x25 frame.
        run_phase(1000,  3000,  25,  200, 630,   1,  0);
        // Shrunk side with the large frame still stored.
        run_phase(0,     0,     5,   64,  100,   1,  0);
        // Largest sides: frames too big to fill here, so only noise.
        run_phase(10,    20,    100, 37,  25,    0,  0);
        run_phase(300,   299,   127, 2,   25,    0,  0);
        run_phase(0,     1,     2,   255, 80,    1,  0);

        wait_for_idle(SETTLE);

        $display("Sent %0d commands over %0d register writes; checked %0d pixels, %0d of them",
                 commands_sent, writes_done, pixels_checked, no_frame_seen);
        $display("no-frame errors, across auto and fixed ranges, replication and side clamps.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
